>>> src/txcid_pkg.sv
package txcid_pkg;

  localparam int unsigned LengthWidth  = 32;
  localparam int unsigned ChainIdWidth = 64;
  localparam int unsigned FifoDepth    = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PhStart,
    PhTypedHdr,
    PhOuterLen,
    PhItemHdr,
    PhItemLen,
    PhItemBody,
    PhDecided
  } phase_e;

  // Verdict codes.
  typedef enum logic [1:0] {
    VUnprot  = 2'd0,
    VProt    = 2'd1,
    VMal     = 2'd2,
    VDeposit = 2'd3
  } verdict_e;

  localparam logic [7:0] DepositByte = 8'h7E;

  // Summary of a finished frame, handed from the parser to the evaluator.
  typedef struct packed {
    phase_e     phase;
    logic [1:0] sticky;
    logic       outer_zero;
    logic       typed;
    logic       r_empty;
    logic       s_empty;
    logic [3:0] field_index;
    logic [63:0] scalar;
  } frame_sum_t;

endpackage

>>> src/txcid_if.sv
interface txcid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       frame_end;
  modport source (output valid, data_byte, has_byte, frame_end, input ready);
  modport sink (input valid, data_byte, has_byte, frame_end, output ready);
endinterface

interface txcid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] chain_id;
  modport source (output valid, verdict, chain_id, input ready);
  modport sink (input valid, verdict, chain_id, output ready);
endinterface

>>> src/txcid_parser.sv
module txcid_parser #(
  parameter int unsigned LENGTH_WIDTH = txcid_pkg::LengthWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  has_byte_i,
  input  logic                  frame_end_i,
  output txcid_pkg::frame_sum_t sum_o
);

  txcid_pkg::phase_e phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] outer_q, outer_d, item_q, item_d, acc_q, acc_d;
  logic [3:0]  lbl_q, lbl_d, fidx_q, fidx_d;
  logic [7:0]  prefix_q, prefix_d;
  logic [63:0] scalar_q, scalar_d;
  logic [2:0]  tf_q, tf_d;
  logic [1:0]  sticky_q, sticky_d;

  // Working values of the combinational step.
  logic        typed, at_scalar, at_sig, len_ok, len_done;
  logic [LENGTH_WIDTH-1:0] acc_next, pl_len;
  logic        pl_go, pl_list;
  logic [7:0]  b;

  assign b = data_byte_i;

  always_comb begin
    phase_d  = phase_q;
    outer_d  = outer_q;
    item_d   = item_q;
    acc_d    = acc_q;
    lbl_d    = lbl_q;
    fidx_d   = fidx_q;
    prefix_d = prefix_q;
    scalar_d = scalar_q;
    tf_d     = tf_q;
    sticky_d = sticky_q;
    pl_go    = 1'b0;
    pl_list  = 1'b0;
    pl_len   = '0;
    typed     = tf_q[0];
    at_scalar = typed ? (fidx_q == 4'd0) : (fidx_q == 4'd6);
    at_sig    = !typed && (fidx_q == 4'd7 || fidx_q == 4'd8);
    // Long-form length byte: no leading zero and no overflow.
    len_ok   = !((acc_q == '0) && (b == 8'd0)) && (acc_q[LENGTH_WIDTH-1 -: 8] == 8'd0);
    acc_next = {acc_q[LENGTH_WIDTH-9:0], b};
    len_done = (lbl_q == 4'd1);

    if (has_byte_i) begin
      unique case (phase_q)
        txcid_pkg::PhDecided: ;
        txcid_pkg::PhStart, txcid_pkg::PhTypedHdr: begin
          if (phase_q == txcid_pkg::PhStart && b == txcid_pkg::DepositByte) begin
            phase_d = txcid_pkg::PhDecided;
            sticky_d = txcid_pkg::VDeposit;
          end else if (phase_q == txcid_pkg::PhStart && b != 8'd0 && b < 8'h80) begin
            tf_d[0] = 1'b1;
            phase_d = txcid_pkg::PhTypedHdr;
          end else if (b < 8'hC0) begin
            phase_d = txcid_pkg::PhDecided;
            sticky_d = txcid_pkg::VMal;
          end else if (b <= 8'hF7) begin
            outer_d = LENGTH_WIDTH'(b - 8'hC0);
            phase_d = txcid_pkg::PhItemHdr;
          end else begin
            lbl_d = 4'(b - 8'hF7);
            acc_d = '0;
            phase_d = txcid_pkg::PhOuterLen;
          end
        end
        txcid_pkg::PhOuterLen: begin
          if (!len_ok) begin
            phase_d = txcid_pkg::PhDecided;
            sticky_d = txcid_pkg::VMal;
          end else begin
            acc_d = acc_next;
            lbl_d = lbl_q - 4'd1;
            if (len_done) begin
              if (acc_next < LENGTH_WIDTH'(56)) begin
                phase_d = txcid_pkg::PhDecided;
                sticky_d = txcid_pkg::VMal;
              end else begin
                outer_d = acc_next;
                phase_d = txcid_pkg::PhItemHdr;
              end
            end
          end
        end
        default: begin
          // Inside the outer list.
          if (outer_q == '0) begin
            phase_d = txcid_pkg::PhDecided;
            sticky_d = txcid_pkg::VMal;
          end else begin
            outer_d = outer_q - 1'b1;
            if (phase_q == txcid_pkg::PhItemHdr) begin
              if (!typed && fidx_q >= 4'd9) begin
                phase_d = txcid_pkg::PhDecided;
                sticky_d = txcid_pkg::VMal;
              end else begin
                prefix_d = b;
                if (b < 8'h80) begin
                  if (at_scalar && b == 8'd0) begin
                    phase_d = txcid_pkg::PhDecided;
                    sticky_d = txcid_pkg::VMal;
                  end else begin
                    if (at_scalar) scalar_d = 64'(b);
                    if (fidx_q != 4'd15) fidx_d = fidx_q + 4'd1;
                    phase_d = txcid_pkg::PhItemHdr;
                  end
                end else if (b <= 8'hB7) begin
                  pl_go = 1'b1;
                  pl_len = LENGTH_WIDTH'(b - 8'h80);
                end else if (b <= 8'hBF) begin
                  lbl_d = 4'(b - 8'hB7);
                  acc_d = '0;
                  phase_d = txcid_pkg::PhItemLen;
                end else if (b <= 8'hF7) begin
                  pl_go = 1'b1;
                  pl_list = 1'b1;
                  pl_len = LENGTH_WIDTH'(b - 8'hC0);
                end else begin
                  lbl_d = 4'(b - 8'hF7);
                  acc_d = '0;
                  phase_d = txcid_pkg::PhItemLen;
                end
              end
            end else if (phase_q == txcid_pkg::PhItemLen) begin
              if (!len_ok) begin
                phase_d = txcid_pkg::PhDecided;
                sticky_d = txcid_pkg::VMal;
              end else begin
                acc_d = acc_next;
                lbl_d = lbl_q - 4'd1;
                if (len_done) begin
                  if (acc_next < LENGTH_WIDTH'(56)) begin
                    phase_d = txcid_pkg::PhDecided;
                    sticky_d = txcid_pkg::VMal;
                  end else begin
                    pl_go = 1'b1;
                    pl_list = prefix_q >= 8'hC0;
                    pl_len = acc_next;
                  end
                end
              end
            end else begin
              // Item body byte.
              if ((prefix_q == 8'h81 && b < 8'h80) ||
                  (at_scalar && scalar_q == 64'd0 && b == 8'd0)) begin
                phase_d = txcid_pkg::PhDecided;
                sticky_d = txcid_pkg::VMal;
              end else begin
                if (at_scalar) scalar_d = {scalar_q[55:0], b};
                item_d = item_q - 1'b1;
                if (item_q == LENGTH_WIDTH'(1)) begin
                  if (fidx_q != 4'd15) fidx_d = fidx_q + 4'd1;
                  phase_d = txcid_pkg::PhItemHdr;
                end
              end
            end
          end
        end
      endcase

      // Start of an item payload; outer_d already holds the decremented count.
      if (pl_go) begin
        if (pl_len > outer_d || (at_scalar && (pl_list || pl_len > LENGTH_WIDTH'(8))) ||
            (at_sig && pl_list)) begin
          phase_d = txcid_pkg::PhDecided;
          sticky_d = txcid_pkg::VMal;
        end else begin
          if (at_scalar) scalar_d = '0;
          if (at_sig && pl_len == '0) begin
            if (fidx_q == 4'd7) tf_d[1] = 1'b1;
            else tf_d[2] = 1'b1;
          end
          if (pl_len == '0) begin
            if (fidx_q != 4'd15) fidx_d = fidx_q + 4'd1;
            phase_d = txcid_pkg::PhItemHdr;
          end else begin
            item_d = pl_len;
            phase_d = txcid_pkg::PhItemBody;
          end
        end
      end
    end

    // Frame summary after this item's byte.
    sum_o.phase       = phase_d;
    sum_o.sticky      = sticky_d;
    sum_o.outer_zero  = (outer_d == '0);
    sum_o.typed       = tf_d[0];
    sum_o.r_empty     = tf_d[1];
    sum_o.s_empty     = tf_d[2];
    sum_o.field_index = fidx_d;
    sum_o.scalar      = scalar_d;
  end

  // State registers; a frame end clears the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= txcid_pkg::PhStart;
      outer_q  <= '0;
      item_q   <= '0;
      acc_q    <= '0;
      lbl_q    <= '0;
      fidx_q   <= '0;
      prefix_q <= '0;
      scalar_q <= '0;
      tf_q     <= '0;
      sticky_q <= '0;
    end else if (take_i) begin
      if (frame_end_i) begin
        phase_q  <= txcid_pkg::PhStart;
        outer_q  <= '0;
        item_q   <= '0;
        acc_q    <= '0;
        lbl_q    <= '0;
        fidx_q   <= '0;
        prefix_q <= '0;
        scalar_q <= '0;
        tf_q     <= '0;
        sticky_q <= '0;
      end else begin
        phase_q  <= phase_d;
        outer_q  <= outer_d;
        item_q   <= item_d;
        acc_q    <= acc_d;
        lbl_q    <= lbl_d;
        fidx_q   <= fidx_d;
        prefix_q <= prefix_d;
        scalar_q <= scalar_d;
        tf_q     <= tf_d;
        sticky_q <= sticky_d;
      end
    end
  end

endmodule

>>> src/txcid_fifo.sv
module txcid_fifo #(
  parameter int unsigned DEPTH = txcid_pkg::FifoDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  txcid_pkg::frame_sum_t data_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output txcid_pkg::frame_sum_t data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  txcid_pkg::frame_sum_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  // Storage for queued frame summaries.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

>>> src/txcid_eval.sv
module txcid_eval #(
  parameter int unsigned CHAIN_ID_WIDTH = txcid_pkg::ChainIdWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  txcid_pkg::frame_sum_t sum_i,
  output logic                  in_ready_o,
  txcid_out_if.source           out
);

  logic [1:0]  verdict_d, verdict_q;
  logic [63:0] cid_d, cid_q, vsub;
  logic        valid_q, fits, vfits;

  assign vsub  = (sum_i.scalar - 64'd35) >> 1;
  assign fits  = (CHAIN_ID_WIDTH >= 64) ? 1'b1 :
                 ((sum_i.scalar >> CHAIN_ID_WIDTH) == 64'd0);
  assign vfits = (CHAIN_ID_WIDTH >= 64) ? 1'b1 : ((vsub >> CHAIN_ID_WIDTH) == 64'd0);

  // Final verdict of a frame.
  always_comb begin
    verdict_d = txcid_pkg::VMal;
    cid_d = '0;
    if (sum_i.phase == txcid_pkg::PhDecided) begin
      verdict_d = sum_i.sticky;
    end else if (sum_i.phase != txcid_pkg::PhItemHdr || !sum_i.outer_zero) begin
      verdict_d = txcid_pkg::VMal;
    end else if (sum_i.typed) begin
      if (sum_i.field_index != 4'd0 && fits) begin
        verdict_d = txcid_pkg::VProt;
        cid_d = sum_i.scalar;
      end
    end else if (sum_i.field_index == 4'd6) begin
      verdict_d = txcid_pkg::VUnprot;
    end else if (sum_i.field_index == 4'd9) begin
      if (sum_i.r_empty && sum_i.s_empty) begin
        if (fits) begin
          verdict_d = txcid_pkg::VProt;
          cid_d = sum_i.scalar;
        end
      end else if (!sum_i.r_empty && !sum_i.s_empty) begin
        if (sum_i.scalar == 64'd27 || sum_i.scalar == 64'd28) begin
          verdict_d = txcid_pkg::VUnprot;
        end else if (sum_i.scalar >= 64'd35 && vfits) begin
          verdict_d = txcid_pkg::VProt;
          cid_d = vsub;
        end
      end
    end
  end

  assign in_ready_o = !valid_q || out.ready;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      verdict_q <= verdict_d;
      cid_q     <= cid_d;
    end
  end

  assign out.valid    = valid_q;
  assign out.verdict  = verdict_q;
  assign out.chain_id = cid_q;

endmodule

>>> src/tx_envelope_chain_id_classifier_top.sv
// Channel | Dir | Payload
// in_ch   | in  | data_byte[7:0], has_byte, frame_end
// out_ch  | out | verdict[1:0], chain_id[63:0]
//
// One input transfer per cycle while the queue is not full; the parser updates its counters
// in the cycle of the transfer. A frame end pushes a summary into a two-entry queue; the
// evaluator registers the verdict, and offers a result once its output register is free.
// Input stalls whenever the queue is full, which happens only while results back up.
// Reset (rst_ni low) clears the parser, the queue and the output register at once.
module tx_envelope_chain_id_classifier_top #(
  parameter int unsigned LENGTH_WIDTH   = txcid_pkg::LengthWidth,
  parameter int unsigned CHAIN_ID_WIDTH = txcid_pkg::ChainIdWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  txcid_in_if.sink     in_ch,
  txcid_out_if.source  out_ch
);

  txcid_pkg::frame_sum_t sum, q_sum;
  logic take, full, empty, ev_ready;

  assign in_ch.ready = !full;
  assign take = in_ch.valid && in_ch.ready;

  txcid_parser #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_parser (
    .clk_i, .rst_ni,
    .take_i(take),
    .data_byte_i(in_ch.data_byte),
    .has_byte_i(in_ch.has_byte),
    .frame_end_i(in_ch.frame_end),
    .sum_o(sum)
  );

  txcid_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(take && in_ch.frame_end),
    .data_i(sum),
    .full_o(full),
    .empty_o(empty),
    .pop_i(!empty && ev_ready),
    .data_o(q_sum)
  );

  txcid_eval #(.CHAIN_ID_WIDTH(CHAIN_ID_WIDTH)) u_eval (
    .clk_i, .rst_ni,
    .in_valid_i(!empty),
    .sum_i(q_sum),
    .in_ready_o(ev_ready),
    .out(out_ch)
  );

endmodule

>>> src/txcid_checker.sv
module txcid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_frame_end_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_verdict_i,
  input logic [63:0] out_chain_id_i
);

  // Chain id is zero unless the verdict is protected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_verdict_i != txcid_pkg::VProt |-> out_chain_id_i == 64'd0)
    else $error("chain id nonzero on a non-protected verdict");

  // A result rises only after its frame end transfer has passed the queue and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_frame_end_i, 2))
    else $error("result appeared without a frame end");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_verdict_i) &&
      $stable(out_chain_id_i))
    else $error("stalled result changed");

  // Input is stalled only while results back up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with an empty output");

endmodule

bind tx_envelope_chain_id_classifier_top txcid_checker u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_ch.valid),
  .in_ready_i(in_ch.ready),
  .in_frame_end_i(in_ch.frame_end),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_verdict_i(out_ch.verdict),
  .out_chain_id_i(out_ch.chain_id)
);

>>> verif/tb_top.sv
module tb_top;
  import txcid_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       frame_end;
    logic       fixed;
    verdict_e   verdict;
    logic [63:0] chain_id;
  } stim_t;

  typedef struct {
    verdict_e    verdict;
    logic [63:0] chain_id;
  } verdict_t;

  localparam int unsigned WatchLimit = 5000;

  logic clk_i;
  logic rst_ni;

  txcid_in_if  in_ch ();
  txcid_out_if out_ch ();

  tx_envelope_chain_id_classifier_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state for the envelope parser.
  phase_e      pr_phase;
  logic [63:0] pr_outer_left;
  logic [63:0] pr_item_left;
  logic [63:0] pr_len_acc;
  int unsigned pr_len_bytes;
  logic [7:0]  pr_prefix;
  int unsigned pr_field;
  logic [63:0] pr_scalar;
  logic        pr_typed;
  logic        pr_r_empty;
  logic        pr_s_empty;
  verdict_e    pr_sticky;

  verdict_t    expected_verdicts[$];
  stim_t       frame_bytes[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  function automatic logic [63:0] chain_id_max();
    return (ChainIdWidth >= 64) ? '1 : ((64'd1 << ChainIdWidth) - 64'd1);
  endfunction

  function automatic void clear_parser();
    pr_phase      = PhStart;
    pr_outer_left = '0;
    pr_item_left  = '0;
    pr_len_acc    = '0;
    pr_len_bytes  = 0;
    pr_prefix     = '0;
    pr_field      = 0;
    pr_scalar     = '0;
    pr_typed      = 1'b0;
    pr_r_empty    = 1'b0;
    pr_s_empty    = 1'b0;
    pr_sticky     = VUnprot;
  endfunction

  function automatic void decide(verdict_e v);
    pr_phase  = PhDecided;
    pr_sticky = v;
  endfunction

  function automatic bit at_scalar();
    return pr_typed ? (pr_field == 0) : (pr_field == 6);
  endfunction

  function automatic bit at_signature();
    return !pr_typed && (pr_field == 7 || pr_field == 8);
  endfunction

  function automatic void finish_item();
    if (pr_field < 15) pr_field++;
    pr_phase = PhItemHdr;
  endfunction

  // Shifts in one long-form length byte; returns 0 once malformed.
  function automatic bit take_length_byte(logic [7:0] b);
    if (pr_len_acc == 0 && b == 0) begin
      decide(VMal);
      return 0;
    end
    if ((pr_len_acc >> (LengthWidth - 8)) != 0) begin
      decide(VMal);
      return 0;
    end
    pr_len_acc = (pr_len_acc << 8) | b;
    pr_len_bytes--;
    return 1;
  endfunction

  function automatic void begin_payload(logic [63:0] len, bit is_list);
    if (len > pr_outer_left) begin
      decide(VMal);
      return;
    end
    if (at_scalar()) begin
      if (is_list || len > 8) begin
        decide(VMal);
        return;
      end
      pr_scalar = '0;
    end
    if (at_signature()) begin
      if (is_list) begin
        decide(VMal);
        return;
      end
      if (len == 0) begin
        if (pr_field == 7) pr_r_empty = 1'b1;
        else pr_s_empty = 1'b1;
      end
    end
    if (len == 0) begin
      finish_item();
    end else begin
      pr_item_left = len;
      pr_phase     = PhItemBody;
    end
  endfunction

  function automatic void outer_header(logic [7:0] b);
    if (b < 8'hC0) begin
      decide(VMal);
    end else if (b <= 8'hF7) begin
      pr_outer_left = 64'(b - 8'hC0);
      pr_phase      = PhItemHdr;
    end else begin
      pr_len_bytes = b - 8'hF7;
      pr_len_acc   = '0;
      pr_phase     = PhOuterLen;
    end
  endfunction

  function automatic void item_header(logic [7:0] b);
    if (!pr_typed && pr_field >= 9) begin
      decide(VMal);
      return;
    end
    pr_prefix = b;
    if (b < 8'h80) begin
      if (at_scalar()) begin
        if (b == 0) begin
          decide(VMal);
          return;
        end
        pr_scalar = 64'(b);
      end
      finish_item();
    end else if (b <= 8'hB7) begin
      begin_payload(64'(b - 8'h80), 0);
    end else if (b <= 8'hBF) begin
      pr_len_bytes = b - 8'hB7;
      pr_len_acc   = '0;
      pr_phase     = PhItemLen;
    end else if (b <= 8'hF7) begin
      begin_payload(64'(b - 8'hC0), 1);
    end else begin
      pr_len_bytes = b - 8'hF7;
      pr_len_acc   = '0;
      pr_phase     = PhItemLen;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (pr_phase)
      PhDecided: return;
      PhStart: begin
        if (b == DepositByte) begin
          decide(VDeposit);
        end else if (b >= 8'h01 && b < 8'h80) begin
          pr_typed = 1'b1;
          pr_phase = PhTypedHdr;
        end else begin
          outer_header(b);
        end
        return;
      end
      PhTypedHdr: begin
        outer_header(b);
        return;
      end
      PhOuterLen: begin
        if (!take_length_byte(b)) return;
        if (pr_len_bytes == 0) begin
          if (pr_len_acc < 56) begin
            decide(VMal);
            return;
          end
          pr_outer_left = pr_len_acc;
          pr_phase      = PhItemHdr;
        end
        return;
      end
      default: ;
    endcase
    // Every byte inside the outer list must fit in it.
    if (pr_outer_left == 0) begin
      decide(VMal);
      return;
    end
    pr_outer_left--;
    if (pr_phase == PhItemHdr) begin
      item_header(b);
    end else if (pr_phase == PhItemLen) begin
      if (!take_length_byte(b)) return;
      if (pr_len_bytes == 0) begin
        if (pr_len_acc < 56) begin
          decide(VMal);
          return;
        end
        begin_payload(pr_len_acc, pr_prefix >= 8'hC0);
      end
    end else begin
      if (pr_prefix == 8'h81 && b < 8'h80) begin
        decide(VMal);
        return;
      end
      if (at_scalar()) begin
        if (pr_scalar == 0 && b == 0) begin
          decide(VMal);
          return;
        end
        pr_scalar = (pr_scalar << 8) | 64'(b);
      end
      pr_item_left--;
      if (pr_item_left == 0) finish_item();
    end
  endfunction

  function automatic verdict_t classify_frame();
    verdict_t r;
    logic [63:0] c;
    r.verdict  = VMal;
    r.chain_id = '0;
    if (pr_phase == PhDecided) begin
      r.verdict = pr_sticky;
      return r;
    end
    if (pr_phase != PhItemHdr || pr_outer_left != 0) return r;
    if (pr_typed) begin
      if (pr_field < 1 || pr_scalar > chain_id_max()) return r;
      r.verdict  = VProt;
      r.chain_id = pr_scalar;
      return r;
    end
    if (pr_field == 6) begin
      r.verdict = VUnprot;
      return r;
    end
    if (pr_field != 9) return r;
    if (pr_r_empty && pr_s_empty) begin
      if (pr_scalar > chain_id_max()) return r;
      r.verdict  = VProt;
      r.chain_id = pr_scalar;
      return r;
    end
    if (pr_r_empty || pr_s_empty) return r;
    if (pr_scalar == 27 || pr_scalar == 28) begin
      r.verdict = VUnprot;
      return r;
    end
    if (pr_scalar < 35) return r;
    c = (pr_scalar - 64'd35) >> 1;
    if (c > chain_id_max()) return r;
    r.verdict  = VProt;
    r.chain_id = c;
    return r;
  endfunction

  // Applies one accepted transfer to the predictor; table rows carry their own result.
  function automatic void predict_transfer(stim_t s);
    verdict_t r;
    if (s.has_byte) parse_byte(s.data_byte);
    if (s.frame_end) begin
      r = classify_frame();
      if (s.fixed) begin
        r.verdict  = s.verdict;
        r.chain_id = s.chain_id;
      end
      expected_verdicts.push_back(r);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Frame builders: bytes go to frame_bytes, the last one carries frame end.
  function automatic void push_byte(logic [7:0] b);
    stim_t s;
    s.data_byte = b;
    s.has_byte  = 1'b1;
    s.frame_end = 1'b0;
    s.fixed     = 1'b0;
    s.verdict   = VUnprot;
    s.chain_id  = '0;
    frame_bytes.push_back(s);
  endfunction

  function automatic void close_frame(bit marker_only);
    stim_t s;
    if (marker_only || frame_bytes.size() == 0) begin
      s.data_byte = 8'($urandom);
      s.has_byte  = 1'b0;
      s.frame_end = 1'b1;
      s.fixed     = 1'b0;
      s.verdict   = VUnprot;
      s.chain_id  = '0;
      frame_bytes.push_back(s);
    end else begin
      frame_bytes[frame_bytes.size() - 1].frame_end = 1'b1;
    end
  endfunction

  // Encodes a scalar canonically (byte below 0x80 alone, else short string).
  function automatic void encode_scalar(ref logic [7:0] q[$], input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) if (v >> (8 * i) != 0) n = i + 1;
    if (n == 1 && v < 64'h80 && v != 0) begin
      q.push_back(v[7:0]);
    end else begin
      q.push_back(8'(8'h80 + n));
      for (int i = n - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic logic [63:0] random_scalar();
    logic [63:0] v;
    int n;
    n = $urandom_range(0, 8);
    v = {$urandom, $urandom};
    if (n < 8) v = v & ((64'd1 << (8 * n)) - 1);
    if ($urandom_range(0, 3) == 0) v = 64'($urandom_range(0, 70));
    return v;
  endfunction

  function automatic void encode_string(ref logic [7:0] q[$], input int len);
    if (len == 1 && $urandom_range(0, 1)) begin
      q.push_back(8'($urandom_range(0, 127)));
      return;
    end
    if (len < 56) begin
      q.push_back(8'(8'h80 + len));
    end else begin
      q.push_back(8'hB8);
      q.push_back(8'(len));
    end
    for (int i = 0; i < len; i++) q.push_back(8'($urandom));
  endfunction

  // Builds a random, mostly well-formed envelope and queues it.
  function automatic void build_envelope();
    logic [7:0] body[$];
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    body = {};
    if (kind <= 3) begin
      // Typed envelope: chain id, then a few more fields.
      encode_scalar(body, random_scalar());
      for (int i = $urandom_range(0, 3); i > 0; i--) encode_string(body, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        body.push_back(8'hC2);
        body.push_back(8'h01);
        body.push_back(8'h02);
      end
    end else if (kind <= 8) begin
      // Legacy envelope with 6 or 9 fields.
      for (int i = 0; i < 6; i++) encode_string(body, $urandom_range(0, 4));
      if (kind >= 5) begin
        encode_scalar(body, random_scalar());
        if (kind == 5) begin
          body.push_back(8'h80);
          body.push_back(8'h80);
        end else begin
          encode_string(body, $urandom_range(kind == 8 ? 0 : 1, 40));
          encode_string(body, $urandom_range(kind == 8 ? 0 : 1, 40));
        end
      end
    end else begin
      for (int i = $urandom_range(0, 12); i > 0; i--) body.push_back(8'($urandom));
    end
    // Occasional corruption of the body.
    if ($urandom_range(0, 9) == 0 && body.size() > 0)
      body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    len = body.size();
    if ($urandom_range(0, 19) == 0) len = len + $urandom_range(0, 2) - 1;
    if (kind <= 3) push_byte(8'($urandom_range(1, 127)));
    if (len < 56) begin
      push_byte(8'(8'hC0 + len));
    end else begin
      push_byte(8'hF8);
      push_byte(8'(len));
    end
    foreach (body[i]) push_byte(body[i]);
    if ($urandom_range(0, 29) == 0) push_byte(8'($urandom));
    if ($urandom_range(0, 19) == 0) begin
      close_frame(1);
    end else begin
      if ($urandom_range(0, 39) == 0 && frame_bytes.size() > 1) void'(frame_bytes.pop_back());
      close_frame(0);
    end
  endfunction

  // Directed rows: byte, has_byte, frame_end, fixed verdict, verdict, chain id.
  stim_t directed_rows[] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, VMal,     64'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h7E, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, VDeposit, 64'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, VMal,     64'd0},
    '{8'h02, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'hC1, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h05, 1'b1, 1'b1, 1'b1, VProt,    64'd5},
    '{8'h01, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'hC2, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h81, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h05, 1'b1, 1'b1, 1'b1, VMal,     64'd0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'hC0, 1'b1, 1'b1, 1'b1, VMal,     64'd0},
    '{8'hF8, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h37, 1'b1, 1'b1, 1'b1, VMal,     64'd0},
    '{8'hC6, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, VUnprot,  64'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, VUnprot,  64'd0},
    '{8'h42, 1'b1, 1'b1, 1'b1, VMal,     64'd0}
  };

  // Sends one transfer after a random gap; valid stays high when no gap follows.
  task automatic send_transfer(stim_t s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= s.data_byte;
    in_ch.has_byte  <= s.has_byte;
    in_ch.frame_end <= s.frame_end;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_transfer(s);
  endtask

  // Stimulus.
  initial begin
    stim_t s;
    int sent;
    clear_parser();
    mismatch_count   = 0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte  = 1'b0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_transfer(directed_rows[i]);
    // Long legacy envelope with v = 37 and a long-form outer length.
    frame_bytes = {};
    push_byte(8'hF8);
    push_byte(8'd61);
    for (int i = 0; i < 6; i++) push_byte(8'h80);
    push_byte(8'd37);
    push_byte(8'hB4);
    for (int i = 0; i < 20; i++) push_byte(8'hAA);
    push_byte(8'hA0);
    for (int i = 0; i < 32; i++) push_byte(8'h55);
    close_frame(0);
    while (frame_bytes.size() > 0) send_transfer(frame_bytes.pop_front());
    // Pause until every expected verdict has arrived.
    in_ch.valid <= 1'b0;
    wait (expected_verdicts.size() == 0);
    sent = 0;
    while (sent < 2000) begin
      frame_bytes = {};
      build_envelope();
      while (frame_bytes.size() > 0) begin
        s = frame_bytes.pop_front();
        send_transfer(s);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    wait (expected_verdicts.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls and field-by-field checking.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict", 64'(out_ch.verdict), 64'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.verdict != want.verdict)
            report_mismatch("verdict", 64'(out_ch.verdict), 64'(want.verdict));
          if (out_ch.chain_id != want.chain_id)
            report_mismatch("chain_id", out_ch.chain_id, want.chain_id);
        end
      end
      if (idle_cycles > 0) begin
        idle_cycles  <= idle_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (!out_ch.ready || out_ch.valid) begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          idle_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // Watchdog on cycles without any transfer.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
